@@ rtl/jsu_pkg.sv @@
`default_nettype none
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumOut  = 4;
  localparam int unsigned CountW  = 3;
  localparam int unsigned StatusW = 2;
  // byte_0..byte_3 and byte_count, padded up to whole bytes
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUsedW = NumOut * ByteW + CountW;

  typedef enum logic [StatusW-1:0] {
    ST_DATA = 2'd0,
    ST_DONE = 2'd1,
    ST_ERR  = 2'd2
  } status_e;

  typedef struct packed {
    logic                          valid;
    logic [NumOut-1:0][ByteW-1:0]  bytes;
    logic [CountW-1:0]             count;
    status_e                       status;
  } jsu_res_t;

  // {ok, value} of an ASCII hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/json_string_unescape_utf8.sv @@
`default_nettype none
// JSON string unescaper producing UTF-8.
// Slave stream: one raw text byte per transaction in s_axis_tdata; s_axis_tuser
// high marks end of the buffer (data byte ignored). Master stream: zero or one
// result per input transaction, carrying up to four UTF-8 bytes, their count,
// and a status in m_axis_tuser (data, string complete, malformed/truncated).
// Whitespace and the opening quote outside a string, a backslash, and the
// leading parts of \uXXXX escapes produce no result.
// A result passes through the input register and then the output register.
// Throughput: one byte per cycle while the receiver takes results, set by the single decode step
// between the input register and the result register.
// Reset clears the parser to idle (outside any string) and empties both
// registers. When the receiver stalls, the result register holds; the input
// register still takes one more byte and moves on while that byte yields no
// result, so s_axis_tready drops only when both registers are occupied.
module json_string_unescape_utf8 (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] in_byte
  input  wire logic                          s_axis_tuser,  // [0] input_ends
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3,
  // [34:32] byte_count, [39:35] zero
  output logic [jsu_pkg::OutDataW-1:0]       m_axis_tdata,
  output logic [jsu_pkg::StatusW-1:0]        m_axis_tuser   // [1:0] status
);
  import jsu_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_ends_q;
  jsu_res_t   res;
  jsu_res_t   out_q;
  logic       advance;

  assign advance = in_valid_q && (!res.valid || !out_q.valid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  jsu_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .in_byte_i    (in_byte_q),
    .input_ends_i (in_ends_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      in_byte_q  <= '0;
      in_ends_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (s_axis_tready && s_axis_tvalid) begin
        in_byte_q <= s_axis_tdata;
        in_ends_q <= s_axis_tuser;
      end
      if (advance && res.valid) begin
        out_q <= res;
      end else if (m_axis_tready) begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_q.valid;
  assign m_axis_tdata  = {(OutDataW - OutUsedW)'(0), out_q.count, out_q.bytes};
  assign m_axis_tuser  = out_q.status;

  a_ctrl_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status != ST_DATA) |-> out_q.count == 3'd0)
    else $error("done or error result carries bytes");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_q.status == ST_DATA)
      |-> (out_q.count != 3'd0 && out_q.count <= 3'd4))
    else $error("data result with bad byte count");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_q.valid && !m_axis_tready))
    else $error("input stalled while a register is free");

endmodule
`default_nettype wire

@@ rtl/jsu_step.sv @@
`default_nettype none
module jsu_step (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            input_ends_i,
  output jsu_pkg::jsu_res_t    res_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE = 3'd0,
    M_STR  = 3'd1,
    M_ESC  = 3'd2,
    M_HEX1 = 3'd3,
    M_BS2  = 3'd4,
    M_U2   = 3'd5,
    M_HEX2 = 3'd6
  } mode_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;

  mode_e       mode_q, mode_d;
  logic [15:0] hex_q, hex_d;
  logic [15:0] high_q, high_d;
  logic [1:0]  cnt_q, cnt_d;

  logic [4:0]  hv;
  logic [15:0] hex_shift;
  logic [31:0] cp;
  jsu_res_t    res;

  assign hv        = hex_value(in_byte_i);
  assign hex_shift = {hex_q[11:0], hv[3:0]};
  // 32-bit wrapping pair combine; low half is not range checked
  assign cp = 32'h0001_0000 + (({16'd0, high_q} - 32'h0000_D800) << 10)
            + ({16'd0, hex_shift} - 32'h0000_DC00);

  always_comb begin
    mode_d = mode_q;
    hex_d  = hex_q;
    high_d = high_q;
    cnt_d  = cnt_q;
    res    = '0;
    res.status = ST_DATA;
    if (input_ends_i) begin
      mode_d = M_IDLE; hex_d = '0; high_d = '0; cnt_d = '0;
      res.valid = 1'b1; res.status = ST_ERR;
    end else begin
      case (mode_q)
        M_STR: begin
          if (in_byte_i == ChQuote) begin
            mode_d = M_IDLE; hex_d = '0; high_d = '0; cnt_d = '0;
            res.valid = 1'b1; res.status = ST_DONE;
          end else if (in_byte_i == ChBslash) begin
            mode_d = M_ESC;
          end else begin
            res.valid = 1'b1; res.count = 3'd1; res.bytes[0] = in_byte_i;
          end
        end
        M_ESC: begin
          mode_d = M_STR;
          res.valid = 1'b1;
          res.count = 3'd1;
          case (in_byte_i)
            8'h22, 8'h5C, 8'h2F: res.bytes[0] = in_byte_i;
            8'h6E: res.bytes[0] = 8'h0A;
            8'h74: res.bytes[0] = 8'h09;
            8'h72: res.bytes[0] = 8'h0D;
            8'h62: res.bytes[0] = 8'h08;
            8'h66: res.bytes[0] = 8'h0C;
            8'h75: begin
              mode_d = M_HEX1; hex_d = '0; cnt_d = '0;
              res = '0;
            end
            default: begin
              mode_d = M_IDLE; hex_d = '0; high_d = '0; cnt_d = '0;
              res = '0; res.valid = 1'b1; res.status = ST_ERR;
            end
          endcase
        end
        M_HEX1, M_HEX2: begin
          if (!hv[4]) begin
            mode_d = M_IDLE; hex_d = '0; high_d = '0; cnt_d = '0;
            res.valid = 1'b1; res.status = ST_ERR;
          end else if (cnt_q != 2'd3) begin
            hex_d = hex_shift;
            cnt_d = cnt_q + 2'd1;
          end else begin
            hex_d = '0;
            cnt_d = '0;
            mode_d = M_STR;
            if (mode_q == M_HEX2) begin
              high_d = '0;
              res.valid = 1'b1; res.count = 3'd4;
              res.bytes[0] = 8'hF0 | cp[25:18];
              res.bytes[1] = {2'b10, cp[17:12]};
              res.bytes[2] = {2'b10, cp[11:6]};
              res.bytes[3] = {2'b10, cp[5:0]};
            end else if (hex_shift < 16'h0080) begin
              res.valid = 1'b1; res.count = 3'd1;
              res.bytes[0] = hex_shift[7:0];
            end else if (hex_shift < 16'h0800) begin
              res.valid = 1'b1; res.count = 3'd2;
              res.bytes[0] = {3'b110, hex_shift[10:6]};
              res.bytes[1] = {2'b10, hex_shift[5:0]};
            end else if (hex_shift[15:10] == 6'b110110) begin
              // high surrogate: hold it and wait for the second escape
              high_d = hex_shift;
              mode_d = M_BS2;
            end else begin
              res.valid = 1'b1; res.count = 3'd3;
              res.bytes[0] = {4'hE, hex_shift[15:12]};
              res.bytes[1] = {2'b10, hex_shift[11:6]};
              res.bytes[2] = {2'b10, hex_shift[5:0]};
            end
          end
        end
        M_BS2, M_U2: begin
          if ((mode_q == M_BS2 && in_byte_i == ChBslash) ||
              (mode_q == M_U2 && in_byte_i == 8'h75)) begin
            if (mode_q == M_BS2) begin
              mode_d = M_U2;
            end else begin
              mode_d = M_HEX2; hex_d = '0; cnt_d = '0;
            end
          end else begin
            mode_d = M_IDLE; hex_d = '0; high_d = '0; cnt_d = '0;
            res.valid = 1'b1; res.status = ST_ERR;
          end
        end
        default: begin
          mode_d = M_IDLE;
          if (in_byte_i inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
            // whitespace between strings
          end else if (in_byte_i == ChQuote) begin
            mode_d = M_STR; hex_d = '0; high_d = '0; cnt_d = '0;
          end else begin
            hex_d = '0; high_d = '0; cnt_d = '0;
            res.valid = 1'b1; res.status = ST_ERR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      hex_q  <= '0;
      high_q <= '0;
      cnt_q  <= '0;
    end else if (en_i) begin
      mode_q <= mode_d;
      hex_q  <= hex_d;
      high_q <= high_d;
      cnt_q  <= cnt_d;
    end
  end

  assign res_o = res;

  a_high_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_BS2 || mode_q == M_U2 || mode_q == M_HEX2)
      |-> high_q[15:10] == 6'b110110)
    else $error("held value is not a high surrogate");

  a_cnt_only_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (mode_q == M_HEX1 || mode_q == M_HEX2))
    else $error("digit count outside hex escape");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == M_IDLE) |-> (hex_q == 16'd0 && high_q == 16'd0))
    else $error("accumulators not cleared while idle");

endmodule
`default_nettype wire

@@ test/json_string_unescape_utf8_tb.sv @@
module json_string_unescape_utf8_tb;
  import jsu_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] in_byte
  logic                s_axis_tuser;   // [0] input_ends
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [7:0] byte_0, [15:8] byte_1, [23:16] byte_2, [31:24] byte_3,
  // [34:32] byte_count, [39:35] zero
  logic [OutDataW-1:0] m_axis_tdata;
  logic [StatusW-1:0]  m_axis_tuser;   // [1:0] status

  json_string_unescape_utf8 i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU = 8'h75;

  typedef enum logic [3:0] {
    P_IDLE, P_STR, P_ESC, P_HEX1, P_BS2, P_U2, P_HEX2
  } scan_mode_e;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    status_e         status;
  } utf8_out_t;

  class unescape_scoreboard;
    scan_mode_e  mode;
    logic [15:0] hex_acc;
    logic [15:0] high_half;
    logic [1:0]  n_digits;
    utf8_out_t   utf8_q[$];
    int unsigned errors;
    int unsigned n_checked;

    function new();
      clear();
      errors = 0;
      n_checked = 0;
    endfunction

    function void clear();
      mode = P_IDLE;
      hex_acc = '0;
      high_half = '0;
      n_digits = '0;
    endfunction

    function void emit(input logic [2:0] n, input logic [7:0] b0, input logic [7:0] b1,
                       input logic [7:0] b2, input logic [7:0] b3, input status_e st);
      utf8_out_t r;
      r.bytes = {b3, b2, b1, b0};
      r.count = n;
      r.status = st;
      utf8_q.insert(utf8_q.size(), r);
    endfunction

    function void fail();
      clear();
      emit(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, ST_ERR);
    endfunction

    // -1 bad digit, 0 more to come, 1 four digits collected
    function int take_digit(input logic [7:0] c);
      logic [3:0] v;
      if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) v = c[3:0] + 4'd9;
      else return -1;
      hex_acc = {hex_acc[11:0], v};
      if (n_digits == 2'd3) begin
        n_digits = 2'd0;
        return 1;
      end
      n_digits = n_digits + 2'd1;
      return 0;
    endfunction

    function void note_byte(input logic [7:0] c, input logic ends);
      int          r;
      logic [15:0] code;
      logic [31:0] cp;
      logic [31:0] s18;
      logic [31:0] s12;
      logic [31:0] s6;
      if (ends) begin
        fail();
        return;
      end
      case (mode)
        P_STR: begin
          if (c == ChQuote) begin
            clear();
            emit(3'd0, 8'h00, 8'h00, 8'h00, 8'h00, ST_DONE);
          end else if (c == ChBslash) begin
            mode = P_ESC;
          end else begin
            emit(3'd1, c, 8'h00, 8'h00, 8'h00, ST_DATA);
          end
        end
        P_ESC: begin
          case (c)
            8'h22, 8'h5C, 8'h2F: code = {8'h00, c};
            8'h6E: code = 16'h000A;
            8'h74: code = 16'h0009;
            8'h72: code = 16'h000D;
            8'h62: code = 16'h0008;
            8'h66: code = 16'h000C;
            ChU: begin
              mode = P_HEX1;
              hex_acc = '0;
              n_digits = '0;
              return;
            end
            default: begin
              fail();
              return;
            end
          endcase
          mode = P_STR;
          emit(3'd1, code[7:0], 8'h00, 8'h00, 8'h00, ST_DATA);
        end
        P_HEX1: begin
          r = take_digit(c);
          if (r < 0) begin
            fail();
          end else if (r == 1) begin
            code = hex_acc;
            hex_acc = '0;
            mode = P_STR;
            if (code < 16'h0080) begin
              emit(3'd1, code[7:0], 8'h00, 8'h00, 8'h00, ST_DATA);
            end else if (code < 16'h0800) begin
              emit(3'd2, 8'hC0 | code[13:6], 8'h80 | {2'b00, code[5:0]}, 8'h00, 8'h00,
                   ST_DATA);
            end else if (code >= 16'hD800 && code <= 16'hDBFF) begin
              high_half = code;
              mode = P_BS2;
            end else begin
              emit(3'd3, 8'hE0 | {4'h0, code[15:12]}, 8'h80 | {2'b00, code[11:6]},
                   8'h80 | {2'b00, code[5:0]}, 8'h00, ST_DATA);
            end
          end
        end
        P_BS2: begin
          if (c != ChBslash) fail();
          else mode = P_U2;
        end
        P_U2: begin
          if (c != ChU) begin
            fail();
          end else begin
            mode = P_HEX2;
            hex_acc = '0;
            n_digits = '0;
          end
        end
        P_HEX2: begin
          r = take_digit(c);
          if (r < 0) begin
            fail();
          end else if (r == 1) begin
            // second half is not range-checked; everything wraps at 32 bits
            cp = 32'h0001_0000 + (({16'h0000, high_half} - 32'h0000_D800) << 10)
                 + ({16'h0000, hex_acc} - 32'h0000_DC00);
            s18 = cp >> 18;
            s12 = cp >> 12;
            s6 = cp >> 6;
            hex_acc = '0;
            high_half = '0;
            mode = P_STR;
            emit(3'd4, 8'hF0 | s18[7:0], 8'h80 | {2'b00, s12[5:0]},
                 8'h80 | {2'b00, s6[5:0]}, 8'h80 | {2'b00, cp[5:0]}, ST_DATA);
          end
        end
        default: begin
          mode = P_IDLE;
          if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
            // whitespace between strings
          end else if (c == ChQuote) begin
            clear();
            mode = P_STR;
          end else begin
            fail();
          end
        end
      endcase
    endfunction

    function void check_result(input logic [OutDataW-1:0] data,
                               input logic [StatusW-1:0] user);
      utf8_out_t want;
      n_checked++;
      if (utf8_q.size() == 0) begin
        $error("unexpected result: tdata=%h tuser=%h", data, user);
        errors++;
        return;
      end
      want = utf8_q.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (data[8*i +: 8] !== want.bytes[i]) begin
          $error("byte_%0d mismatch: expected %h, got %h", i, want.bytes[i], data[8*i +: 8]);
          errors++;
        end
      end
      if (data[34:32] !== want.count) begin
        $error("byte_count mismatch: expected %0d, got %0d", want.count, data[34:32]);
        errors++;
      end
      if (user !== want.status) begin
        $error("status mismatch: expected %0d, got %0d", want.status, user);
        errors++;
      end
    endfunction
  endclass

  unescape_scoreboard chk = new();

  // {input_ends, in_byte}
  logic [8:0] text_q[$];
  logic       calm_tx;
  logic       calm_rx;

  function automatic void put(input logic [7:0] c);
    text_q.insert(text_q.size(), {1'b0, c});
  endfunction

  function automatic void put_end();
    text_q.insert(text_q.size(), {1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, v} - 8'd10;
  endfunction

  function automatic void put_u_escape(input logic [15:0] v);
    put(ChBslash);
    put(ChU);
    for (int i = 3; i >= 0; i--) put(hex_char(v[4*i +: 4]));
  endfunction

  function automatic logic [7:0] non_hex_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(8'h00, 8'h2F));
      1: return 8'($urandom_range(8'h3A, 8'h40));
      2: return 8'($urandom_range(8'h47, 8'h60));
      default: return 8'($urandom_range(8'h67, 8'hFF));
    endcase
  endfunction

  function automatic logic [15:0] rand_code();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(16'h0000, 16'h007F));
      1: return 16'($urandom_range(16'h0080, 16'h07FF));
      2: return 16'($urandom_range(16'h0800, 16'hD7FF));
      3: return 16'($urandom_range(16'hDC00, 16'hDFFF));
      default: return 16'($urandom_range(16'hE000, 16'hFFFF));
    endcase
  endfunction

  function automatic void put_whitespace();
    case ($urandom_range(0, 3))
      0: put(8'h20);
      1: put(8'h09);
      2: put(8'h0A);
      default: put(8'h0D);
    endcase
  endfunction

  // one mostly well-formed string; a broken one stops at the offending byte
  function automatic void gen_string();
    int          ntok;
    int          brk;
    logic [7:0]  c;
    logic [15:0] hi;
    repeat ($urandom_range(0, 2)) put_whitespace();
    put(ChQuote);
    ntok = $urandom_range(0, 8);
    brk = ($urandom_range(0, 6) == 0) ? $urandom_range(0, ntok) : -1;
    for (int t = 0; t <= ntok; t++) begin
      if (t == brk) begin
        case ($urandom_range(0, 5))
          0: begin
            c = 8'($urandom_range(0, 255));
            if (c inside {8'h22, 8'h5C, 8'h2F, 8'h6E, 8'h74, 8'h72, 8'h62, 8'h66, 8'h75})
              c = 8'h61;
            put(ChBslash);
            put(c);
          end
          1: begin
            put(ChBslash);
            put(ChU);
            repeat ($urandom_range(0, 3)) put(hex_char(4'($urandom_range(0, 15))));
            put(non_hex_char());
          end
          2: begin
            put_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            c = 8'($urandom_range(0, 255));
            put(c == ChBslash ? 8'h41 : c);
          end
          3: begin
            put_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            put(ChBslash);
            c = 8'($urandom_range(0, 255));
            put(c == ChU ? 8'h55 : c);
          end
          4: begin
            put_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
            put(ChBslash);
            put(ChU);
            repeat ($urandom_range(0, 3)) put(hex_char(4'($urandom_range(0, 15))));
            put(non_hex_char());
          end
          default: begin
            put_end();
          end
        endcase
        return;
      end
      if (t == ntok) break;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          c = 8'($urandom_range(0, 255));
          put((c == ChQuote || c == ChBslash) ? ~c : c);
        end
        4: begin
          put(ChBslash);
          case ($urandom_range(0, 7))
            0: put(8'h22);
            1: put(8'h5C);
            2: put(8'h2F);
            3: put(8'h6E);
            4: put(8'h74);
            5: put(8'h72);
            6: put(8'h62);
            default: put(8'h66);
          endcase
        end
        5, 6: put_u_escape(rand_code());
        default: begin
          hi = 16'($urandom_range(16'hD800, 16'hDBFF));
          put_u_escape(hi);
          // the low half is usually a proper low surrogate, sometimes anything
          put_u_escape($urandom_range(0, 3) ? 16'($urandom_range(16'hDC00, 16'hDFFF))
                                            : 16'($urandom_range(0, 16'hFFFF)));
        end
      endcase
    end
    put(ChQuote);
  endfunction

  task automatic send_item(input logic [8:0] item);
    int gap;
    if ($urandom_range(0, 63) == 0) calm_tx = !calm_tx;
    gap = calm_tx ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= item[7:0];
    s_axis_tuser <= item[8];
    do @(posedge clk_i); while (!s_axis_tready);
    chk.note_byte(item[7:0], item[8]);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_400_000;
    $display("simulation failed");
    $finish;
  end

  // result side: random stalls, one long hold-off so the input backs up
  initial begin
    int  gap;
    bit  held;
    held = 0;
    calm_rx = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 63) == 0) calm_rx = !calm_rx;
      gap = calm_rx ? 0 : $urandom_range(0, 3);
      if (!held && chk.n_checked >= 150) begin
        gap = 300;
        held = 1;
      end
      repeat (gap) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      chk.check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    calm_tx = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;

    // directed: extremes of plain bytes, an escaped quote, the 2-byte limit,
    // a surrogate pair, a stray byte while idle and end of input
    put(8'h20);
    put(ChQuote);
    put(8'hFF);
    put(8'h00);
    put(ChBslash);
    put(ChQuote);
    put_u_escape(16'h07FF);
    put_u_escape(16'hD83D);
    put_u_escape(16'hDE00);
    put(ChQuote);
    put(8'h78);
    put_end();

    while (text_q.size() < 1950) begin
      case ($urandom_range(0, 11))
        0: put_end();
        1: begin
          // stray byte outside a string; a quote would open one
          put(8'($urandom_range(0, 255)) ^ 8'h00);
          if (text_q[$][7:0] == ChQuote) text_q[$] = {1'b0, 8'h7B};
        end
        default: gen_string();
      endcase
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (text_q[i]) send_item(text_q[i]);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (chk.utf8_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (chk.errors == 0 && chk.utf8_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
